/* src/gsp_pkg.sv */
// Shared types, codes and constant tables of the GNSS sentence parser.
// No dependencies; every other file of the block imports this package.
package gsp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // Sentence heads, index 0 is $GPGGA, 1 $GNGGA, 2 $GPRMC, 3 $GNRMC.
  localparam logic [3:0][47:0] PREFIX_TEXT = {"$GNRMC", "$GPRMC", "$GNGGA", "$GPGGA"};

  localparam logic [1:0] TYPE_GGA  = 2'd0;
  localparam logic [1:0] TYPE_RMC  = 2'd1;
  localparam logic [1:0] TYPE_NONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [2:0] SLOT_LAT    = 3'd0;
  localparam logic [2:0] SLOT_LON    = 3'd1;
  localparam logic [2:0] SLOT_FIXQ   = 3'd2;
  localparam logic [2:0] SLOT_SATS   = 3'd3;
  localparam logic [2:0] SLOT_ALT    = 3'd4;
  localparam logic [2:0] SLOT_SPEED  = 3'd5;
  localparam logic [2:0] SLOT_COURSE = 3'd6;

  localparam int NUM_SLOTS = 7;

  localparam logic [31:0] LIMIT_ALT    = 32'd100000000;
  localparam logic [31:0] LIMIT_SPEED  = 32'd1000000000;
  localparam logic [31:0] LIMIT_COURSE = 32'd1000000;
  localparam logic [31:0] COORD_MAX    = 32'd2147483647;

  typedef enum logic [2:0] {
    KIND_COORD,
    KIND_COUNT,
    KIND_ALT,
    KIND_SPEED,
    KIND_COURSE
  } kind_t;

  // Pending-store operations that a byte causes, applied in this order:
  // clear, set flags, field write, commit, clear.
  typedef struct packed {
    logic       pre_clr;
    logic       set_lat_neg;
    logic       set_lon_neg;
    logic       set_active;
    logic       commit;
    logic [1:0] ctype;
    logic       post_clr;
  } ctl_t;

  typedef struct packed {
    logic        wr;
    logic [2:0]  slot;
    kind_t       kind;
    logic [31:0] n_int;
    logic [19:0] n_frac;
    logic        n_neg;
    logic        short_coord;
  } field_t;

  typedef struct packed {
    logic   valid;
    ctl_t   ctl;
    field_t fld;
  } pkt_t;

  function automatic logic [31:0] pow10(input logic [2:0] k);
    logic [31:0] r;
    unique case (k)
      3'd0: r = 32'd1;
      3'd1: r = 32'd10;
      3'd2: r = 32'd100;
      3'd3: r = 32'd1000;
      3'd4: r = 32'd10000;
      3'd5: r = 32'd100000;
      3'd6: r = 32'd1000000;
      3'd7: r = 32'd10000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

/* src/gsp_parser.sv */
// Byte scanner: line count, prefix match, field split and number accumulate.
// Depends on gsp_pkg; emits one registered pkt_t per accepted byte.
module gsp_parser
  import gsp_pkg::*;
#(
  parameter int LINE_BYTES      = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output pkt_t       pkt
);

  localparam int LCW = $clog2(LINE_BYTES);
  localparam logic [LCW-1:0] LC_LAST = LCW'(LINE_BYTES - 1);
  localparam logic [LCW-1:0] LC_SIX  = LCW'(6);
  localparam logic [2:0] FULL_PHASE = 3'(FRACTION_DIGITS + 1);
  localparam logic [2:0] FD_TOP     = 3'(FRACTION_DIGITS);

  logic [LCW-1:0] line_count, line_count_next;
  logic [3:0]     prefix_live, prefix_live_next;
  logic [4:0]     field_number, field_number_next;
  logic [4:0]     field_chars, field_chars_next;
  logic [31:0]    number_integer, number_integer_next;
  logic [19:0]    number_fraction, number_fraction_next;
  logic [2:0]     fraction_digits, fraction_digits_next;
  logic           number_negative, number_negative_next;
  pkt_t           pkt_next;

  always_comb begin
    logic        line_end, in_range, taking, gga, rmc, coord, digit, neg_dir, do_end;
    logic [3:0]  d;
    logic [35:0] acc;
    lc_init: begin end
    line_count_next      = line_count;
    prefix_live_next     = prefix_live;
    field_number_next    = field_number;
    field_chars_next     = field_chars;
    number_integer_next  = number_integer;
    number_fraction_next = number_fraction;
    fraction_digits_next = fraction_digits;
    number_negative_next = number_negative;
    pkt_next             = '0;
    pkt_next.valid       = take;
    line_end = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    d        = 4'(rx_byte - CH_ZERO);
    neg_dir  = (rx_byte == CH_S) || (rx_byte == CH_W);
    acc      = 36'(number_integer) * 36'd10 + 36'(d);

    if (rx_byte == CH_DOLLAR) begin
      line_count_next      = '0;
      prefix_live_next     = 4'hF;
      field_number_next    = '0;
      field_chars_next     = '0;
      number_integer_next  = '0;
      number_fraction_next = '0;
      fraction_digits_next = '0;
      number_negative_next = 1'b0;
      pkt_next.ctl.pre_clr = 1'b1;
    end

    in_range = line_count_next < LC_LAST;
    if (in_range) begin
      if (line_count_next < LC_SIX) begin
        for (int i = 0; i < 4; i++) begin
          if (PREFIX_TEXT[i][(5 - int'(line_count_next[2:0])) * 8 +: 8] != rx_byte)
            prefix_live_next[i] = 1'b0;
        end
      end
      line_count_next = line_count_next + LCW'(1);
    end
    taking = in_range && !line_end;
    gga    = prefix_live_next[1:0] != 2'b00;
    rmc    = !gga && (prefix_live_next[3:2] != 2'b00);
    coord  = (gga && (field_number_next == 5'd2 || field_number_next == 5'd4)) ||
             (rmc && (field_number_next == 5'd3 || field_number_next == 5'd5));

    if (taking && rx_byte != CH_COMMA) begin
      if (field_chars_next == 5'd0) begin
        pkt_next.ctl.set_lat_neg = neg_dir &&
          ((gga && field_number_next == 5'd3) || (rmc && field_number_next == 5'd4));
        pkt_next.ctl.set_lon_neg = neg_dir &&
          ((gga && field_number_next == 5'd5) || (rmc && field_number_next == 5'd6));
        pkt_next.ctl.set_active = rmc && field_number_next == 5'd2 && rx_byte == CH_A;
      end
      if (!coord || field_chars_next < 5'd15) begin
        if (fraction_digits_next == 3'd0) begin
          if (digit) begin
            number_integer_next = (acc > 36'hFFFFFFFF) ? 32'hFFFFFFFF : acc[31:0];
          end else if (rx_byte == CH_DOT) begin
            fraction_digits_next = 3'd1;
          end else if ((rx_byte == CH_MINUS || rx_byte == CH_PLUS) &&
                       field_chars_next == 5'd0) begin
            number_negative_next = rx_byte == CH_MINUS;
          end else begin
            fraction_digits_next = FULL_PHASE;
          end
        end else if (fraction_digits_next < FULL_PHASE) begin
          if (digit) begin
            // Weight of this digit: 10^(FRACTION_DIGITS - position).
            number_fraction_next = number_fraction_next +
              20'(32'(d) * pow10(FD_TOP - fraction_digits_next));
            fraction_digits_next = fraction_digits_next + 3'd1;
          end else begin
            fraction_digits_next = FULL_PHASE;
          end
        end
      end
      if (field_chars_next < 5'd31) field_chars_next = field_chars_next + 5'd1;
    end

    do_end = (taking && rx_byte == CH_COMMA) || (line_end && line_count_next > LC_SIX);
    if (do_end) begin
      pkt_next.fld.n_int       = number_integer_next;
      pkt_next.fld.n_frac      = number_fraction_next;
      pkt_next.fld.n_neg       = number_negative_next;
      pkt_next.fld.short_coord = field_chars_next < 5'd4;
      pkt_next.fld.kind        = KIND_COORD;
      pkt_next.fld.slot        = SLOT_LAT;
      if (gga) begin
        priority case (field_number_next)
          5'd2: begin pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_LAT; end
          5'd4: begin pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_LON; end
          5'd6: begin
            pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_FIXQ;
            pkt_next.fld.kind = KIND_COUNT;
          end
          5'd7: begin
            pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_SATS;
            pkt_next.fld.kind = KIND_COUNT;
          end
          5'd9: begin
            pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_ALT;
            pkt_next.fld.kind = KIND_ALT;
          end
          default: pkt_next.fld.wr = 1'b0;
        endcase
      end else if (rmc) begin
        priority case (field_number_next)
          5'd3: begin pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_LAT; end
          5'd5: begin pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_LON; end
          5'd7: begin
            pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_SPEED;
            pkt_next.fld.kind = KIND_SPEED;
          end
          5'd8: begin
            pkt_next.fld.wr = 1'b1; pkt_next.fld.slot = SLOT_COURSE;
            pkt_next.fld.kind = KIND_COURSE;
          end
          default: pkt_next.fld.wr = 1'b0;
        endcase
      end
      if (field_number_next < 5'd31) field_number_next = field_number_next + 5'd1;
      field_chars_next     = '0;
      number_integer_next  = '0;
      number_fraction_next = '0;
      fraction_digits_next = '0;
      number_negative_next = 1'b0;
    end

    if (line_end) begin
      if (line_count_next > LC_SIX) begin
        pkt_next.ctl.commit = 1'b1;
        pkt_next.ctl.ctype  = gga ? TYPE_GGA : (rmc ? TYPE_RMC : TYPE_NONE);
      end
      pkt_next.ctl.post_clr = 1'b1;
      line_count_next       = '0;
      prefix_live_next      = 4'hF;
      field_number_next     = '0;
      field_chars_next      = '0;
      number_integer_next   = '0;
      number_fraction_next  = '0;
      fraction_digits_next  = '0;
      number_negative_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count      <= '0;
      prefix_live     <= 4'hF;
      field_number    <= '0;
      field_chars     <= '0;
      number_integer  <= '0;
      number_fraction <= '0;
      fraction_digits <= '0;
      number_negative <= 1'b0;
      pkt             <= '0;
    end else if (en) begin
      pkt <= pkt_next;
      if (take) begin
        line_count      <= line_count_next;
        prefix_live     <= prefix_live_next;
        field_number    <= field_number_next;
        field_chars     <= field_chars_next;
        number_integer  <= number_integer_next;
        number_fraction <= number_fraction_next;
        fraction_digits <= fraction_digits_next;
        number_negative <= number_negative_next;
      end
    end
  end

endmodule

/* src/gsp_convert.sv */
// Six-stage pipeline that turns a finished field into its fixed-point value.
// Depends on gsp_pkg; divisions by constants use reciprocal multiply plus fixup.
module gsp_convert
  import gsp_pkg::*;
#(
  parameter int FRACTION_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  pkt_t        pkt_in,
  output pkt_t        pkt_out,
  output logic [31:0] value
);

  localparam logic [63:0] TWO32    = 64'd1 << 32;
  localparam logic [31:0] DEN      = pow10(3'(FRACTION_DIGITS));
  localparam logic [31:0] HALF_DEN = DEN / 2;
  localparam logic [63:0] M_DEN    = TWO32 / 64'(DEN);
  localparam logic [63:0] M_100    = TWO32 / 64'd100;
  localparam logic [63:0] M_15     = TWO32 / 64'd15;
  localparam logic [31:0] FR_SCALE = pow10(3'(7 - FRACTION_DIGITS));

  // stage 1
  pkt_t        p1;
  logic [25:0] q100a1;
  logic [31:0] z1;
  logic [42:0] nm1;
  // stage 2
  pkt_t        p2;
  logic [25:0] deg2;
  logic [6:0]  rem2;
  logic [31:0] z2;
  logic [11:0] zqa2;
  logic [42:0] nm2;
  // stage 3
  pkt_t        p3;
  logic [11:0] zq3;
  logic [29:0] x3;
  logic [49:0] degm3;
  logic [42:0] nm3;
  // stage 4
  pkt_t        p4;
  logic [29:0] sc4;
  logic [27:0] y4;
  logic [23:0] yqa4;
  logic [49:0] degm4;
  // stage 5
  pkt_t        p5;
  logic [29:0] sc5;
  logic [23:0] yq5;
  logic [49:0] degm5;

  logic [63:0] q100_prod, zq_prod, yq_prod;
  logic [10:0] mult;
  logic [31:0] r100, zr, deg_rem;
  logic [27:0] yr;
  logic [43:0] sc_full, limit;
  logic [49:0] mag;
  logic [30:0] mag_sat;
  logic [31:0] value_next;

  always_comb begin
    mult      = (pkt_in.fld.kind == KIND_SPEED) ? 11'd1852 : 11'd100;
    q100_prod = 64'(pkt_in.fld.n_int) * M_100;
    r100      = p1.fld.n_int - 32'(q100a1) * 32'd100;
    zq_prod   = 64'(z1) * M_DEN;
    zr        = z2 - 32'(zqa2) * DEN;
    deg_rem   = 32'(rem2) * 32'd10000000 + 32'(p2.fld.n_frac) * FR_SCALE + 32'd30;
    sc_full   = 44'(nm3) + 44'(zq3);
    unique case (p3.fld.kind)
      KIND_SPEED:  limit = 44'(LIMIT_SPEED);
      KIND_COURSE: limit = 44'(LIMIT_COURSE);
      default:     limit = 44'(LIMIT_ALT);
    endcase
    yq_prod   = 64'(x3[29:2]) * M_15;
    yr        = y4 - 28'(yqa4) * 28'd15;
    mag       = degm5 + 50'(yq5);
    mag_sat   = (mag > 50'(COORD_MAX)) ? COORD_MAX[30:0] : mag[30:0];
    unique case (p5.fld.kind)
      KIND_COORD:
        value_next = p5.fld.short_coord ? 32'd0 :
                     (p5.fld.n_neg ? 32'd0 - 32'(mag_sat) : 32'(mag_sat));
      KIND_COUNT:
        value_next = p5.fld.n_neg ? 32'd0 :
                     ((p5.fld.n_int > 32'd255) ? 32'd255 : p5.fld.n_int);
      KIND_ALT:
        value_next = p5.fld.n_neg ? 32'd0 - 32'(sc5) : 32'(sc5);
      KIND_SPEED, KIND_COURSE:
        value_next = p5.fld.n_neg ? 32'd0 : 32'(sc5);
      default:
        value_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0; p2.valid <= 1'b0; p3.valid <= 1'b0;
      p4.valid <= 1'b0; p5.valid <= 1'b0; pkt_out.valid <= 1'b0;
    end else if (en) begin
      p1.valid <= pkt_in.valid; p2.valid <= p1.valid; p3.valid <= p2.valid;
      p4.valid <= p3.valid; p5.valid <= p4.valid; pkt_out.valid <= p5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1.ctl <= pkt_in.ctl; p1.fld <= pkt_in.fld;
      q100a1 <= q100_prod[57:32];
      z1     <= 32'(pkt_in.fld.n_frac) * 32'(mult) + HALF_DEN;
      nm1    <= 43'(pkt_in.fld.n_int) * 43'(mult);

      p2.ctl <= p1.ctl; p2.fld <= p1.fld;
      deg2   <= (r100 >= 32'd100) ? q100a1 + 26'd1 : q100a1;
      rem2   <= (r100 >= 32'd100) ? 7'(r100 - 32'd100) : 7'(r100);
      z2     <= z1;
      zqa2   <= zq_prod[43:32];
      nm2    <= nm1;

      p3.ctl <= p2.ctl; p3.fld <= p2.fld;
      zq3    <= (zr >= DEN) ? zqa2 + 12'd1 : zqa2;
      x3     <= deg_rem[29:0];
      degm3  <= 50'(deg2) * 50'd10000000;
      nm3    <= nm2;

      p4.ctl <= p3.ctl; p4.fld <= p3.fld;
      sc4    <= (sc_full > limit) ? limit[29:0] : sc_full[29:0];
      y4     <= x3[29:2];
      yqa4   <= yq_prod[55:32];
      degm4  <= degm3;

      p5.ctl <= p4.ctl; p5.fld <= p4.fld;
      sc5    <= sc4;
      yq5    <= (yr >= 28'd15) ? yqa4 + 24'd1 : yqa4;
      degm5  <= degm4;

      pkt_out.ctl <= p5.ctl; pkt_out.fld <= p5.fld;
      value       <= value_next;
    end
  end

endmodule

/* src/gsp_commit.sv */
// Pending field store, kept fix record and the output register.
// Depends on gsp_pkg; applies clear, flag, write and commit in item order.
module gsp_commit
  import gsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pkt_t         pkt,
  input  logic [31:0]  value,
  output logic         en,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,
  output logic [3:0]   m_tuser
);

  logic [31:0] pend [NUM_SLOTS];
  logic [31:0] pv   [NUM_SLOTS];
  logic [9:0]  pflags, pflags_next, f;

  logic [31:0] kept_lat, kept_lon, lat_next, lon_next;
  logic [7:0]  kept_fixq, kept_sats, fixq_next, sats_next;
  logic [27:0] kept_alt, alt_next;
  logic [29:0] kept_speed, speed_next;
  logic [19:0] kept_course, course_next;
  logic        kept_valid, valid_next;
  logic        fire;
  logic [1:0]  status;

  assign en   = !m_tvalid || m_tready;
  assign fire = en && pkt.valid;

  always_comb begin
    f = pflags;
    if (pkt.ctl.pre_clr) f = '0;
    f[7] = f[7] | pkt.ctl.set_lat_neg;
    f[8] = f[8] | pkt.ctl.set_lon_neg;
    f[9] = f[9] | pkt.ctl.set_active;
    if (pkt.fld.wr) f[pkt.fld.slot] = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++)
      pv[i] = (pkt.fld.wr && pkt.fld.slot == 3'(i)) ? value : pend[i];
    pflags_next = pkt.ctl.post_clr ? '0 : f;

    lat_next    = kept_lat;
    lon_next    = kept_lon;
    fixq_next   = kept_fixq;
    sats_next   = kept_sats;
    alt_next    = kept_alt;
    speed_next  = kept_speed;
    course_next = kept_course;
    valid_next  = kept_valid;
    if (pkt.ctl.ctype != TYPE_NONE) begin
      lat_next = f[SLOT_LAT] ? pv[SLOT_LAT] : 32'd0;
      if (f[7]) lat_next = 32'd0 - lat_next;
      lon_next = f[SLOT_LON] ? pv[SLOT_LON] : 32'd0;
      if (f[8]) lon_next = 32'd0 - lon_next;
      if (pkt.ctl.ctype == TYPE_GGA) begin
        if (f[SLOT_FIXQ]) fixq_next = pv[SLOT_FIXQ][7:0];
        if (f[SLOT_SATS]) sats_next = pv[SLOT_SATS][7:0];
        if (f[SLOT_ALT])  alt_next  = pv[SLOT_ALT][27:0];
        valid_next = fixq_next != 8'd0;
      end else begin
        if (f[SLOT_SPEED])  speed_next  = pv[SLOT_SPEED][29:0];
        if (f[SLOT_COURSE]) course_next = pv[SLOT_COURSE][19:0];
        valid_next = f[9];
      end
    end
    status = (pkt.ctl.ctype == TYPE_NONE) ? ST_UNKNOWN : (valid_next ? ST_OK : ST_INVALID);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pflags      <= '0;
      kept_lat    <= '0;
      kept_lon    <= '0;
      kept_fixq   <= '0;
      kept_sats   <= '0;
      kept_alt    <= '0;
      kept_speed  <= '0;
      kept_course <= '0;
      kept_valid  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (fire) begin
        pflags <= pflags_next;
        if (pkt.ctl.commit) begin
          kept_lat    <= lat_next;
          kept_lon    <= lon_next;
          kept_fixq   <= fixq_next;
          kept_sats   <= sats_next;
          kept_alt    <= alt_next;
          kept_speed  <= speed_next;
          kept_course <= course_next;
          kept_valid  <= valid_next;
          m_tvalid    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pkt.fld.wr) pend[pkt.fld.slot] <= value;
    if (fire && pkt.ctl.commit) begin
      m_tuser <= {pkt.ctl.ctype, status};
      m_tdata <= {course_next, speed_next, alt_next, lon_next, lat_next,
                  sats_next, fixq_next, valid_next && fixq_next != 8'd0, valid_next};
    end
  end

endmodule

/* src/gnss_sentence_parser_unit.sv */
// GNSS sentence parser: NMEA GGA / RMC lines in, one fix record per line end that follows at least six line bytes.
// Throughput: one byte per cycle while the output register is not held by the sink.
// A result passes from its accepted CR or LF byte through the scanner register,
// six conversion stages and the output register.
// Reset (rst, synchronous, active high) empties the pipeline and output
// register, clears the kept record and restarts line scanning.
module gnss_sentence_parser_unit
  import gsp_pkg::*;
#(
  parameter int LINE_BYTES      = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] fix_valid, [1] has_fix, [9:2] fix_quality, [17:10] satellite_count,
  // [49:18] latitude, [81:50] longitude, [109:82] altitude_cm,
  // [139:110] speed_mkmh, [159:140] course_centideg
  output logic [159:0] m_tdata,
  output logic [3:0]   m_tuser    // [1:0] status, [3:2] sentence_type
);

  // The whole chain advances together; it holds only while a finished
  // result waits in the output register and the sink is not taking it.
  logic        en;
  logic        take;
  pkt_t        scan_pkt, conv_pkt;
  logic [31:0] conv_value;

  assign s_tready = en;
  assign take     = s_tvalid && en;

  // Scan each byte: prefix match, field split, digit accumulate.
  gsp_parser #(
    .LINE_BYTES     (LINE_BYTES),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .take   (take),
    .rx_byte(s_tdata),
    .pkt    (scan_pkt)
  );

  // Convert a finished field: ddmm.mmmm to 1e-7 degree, knots to 0.001 km/h,
  // metres and degrees to hundredths, counts clamped to a byte.
  gsp_convert #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_convert (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .pkt_in (scan_pkt),
    .pkt_out(conv_pkt),
    .value  (conv_value)
  );

  // Store pending fields, commit on a line end, drive the result.
  gsp_commit u_commit (
    .clk     (clk),
    .rst     (rst),
    .pkt     (conv_pkt),
    .value   (conv_value),
    .en      (en),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
